### sv/tccw_pkg.sv
// tccw_pkg: shared types, codes and defaults for the text console cell writer.
// Used by every module under sv/ but tccw_ram; depends on nothing.
package tccw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CELL_W   = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, CH_SPACE};

  // register index of text_attribute (byte address 4*index)
  localparam logic REG_TEXT_ATTR = 1'b0;

  typedef enum logic [1:0] {
    ACT_PUT      = 2'd0,
    ACT_WRITE_AT = 2'd1,
    ACT_READ     = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_PUT,
    KIND_CR,
    KIND_LF,
    KIND_TAB,
    KIND_WRITE_AT,
    KIND_READ,
    KIND_CLEAR
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SCROLL,
    ST_FILL,
    ST_RESULT
  } back_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] cell_attribute;
    logic [6:0] cell_column;
    logic [4:0] cell_row;
  } item_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic        scrolled;
  } result_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] char_code;
    logic [7:0] cell_attribute;
    logic [6:0] cell_column;
    logic [4:0] cell_row;
    logic       in_range;
  } cmd_t;

  // queue status seen by the front
  typedef struct packed {
    logic push;
    logic full;
  } queue_ctl_t;

endpackage

### sv/tccw_ram.sv
// tccw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/tccw_queue.sv
// tccw_queue: short command FIFO between front and back.
// Depends on tccw_pkg (cmd_t).
module tccw_queue #(
  parameter int DEPTH = tccw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tccw_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tccw_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tccw_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/tccw_front.sv
// tccw_front: accepts input transfers, decodes action and control characters.
// Depends on tccw_pkg (item_t, cmd_t, codes); feeds tccw_queue.
module tccw_front #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 init_active,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  tccw_pkg::item_t      item,
  output tccw_pkg::queue_ctl_t qctl_out,
  input  logic                 queue_full,
  output tccw_pkg::cmd_t       cmd
);

  logic           cmd_valid;
  logic           accept;
  tccw_pkg::cmd_t cmd_next;

  assign item_stall = init_active || (cmd_valid && queue_full);
  assign accept     = item_valid && !item_stall;

  assign qctl_out.push = cmd_valid;
  assign qctl_out.full = queue_full;

  always_comb begin
    cmd_next.char_code      = item.char_code;
    cmd_next.cell_attribute = item.cell_attribute;
    cmd_next.cell_column    = item.cell_column;
    cmd_next.cell_row       = item.cell_row;
    cmd_next.in_range       = (32'(item.cell_column) < COLUMNS) &&
                              (32'(item.cell_row) < ROWS);
    unique case (tccw_pkg::action_t'(item.action))
      tccw_pkg::ACT_PUT: begin
        case (item.char_code)
          tccw_pkg::CH_CR:  cmd_next.kind = tccw_pkg::KIND_CR;
          tccw_pkg::CH_LF:  cmd_next.kind = tccw_pkg::KIND_LF;
          tccw_pkg::CH_TAB: cmd_next.kind = tccw_pkg::KIND_TAB;
          default:          cmd_next.kind = tccw_pkg::KIND_PUT;
        endcase
      end
      tccw_pkg::ACT_WRITE_AT: cmd_next.kind = tccw_pkg::KIND_WRITE_AT;
      tccw_pkg::ACT_READ:     cmd_next.kind = tccw_pkg::KIND_READ;
      default:                cmd_next.kind = tccw_pkg::KIND_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (!queue_full) begin
      cmd_valid <= 1'b0;
    end
  end

endmodule

### sv/tccw_back.sv
// tccw_back: executes queued commands against the cell store, owns the cursor,
// walks scroll/clear/init fills and holds the result register.
// Depends on tccw_pkg and tccw_ram.
module tccw_back #(
  parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tccw_pkg::ROWS_DEF,
  parameter int TAB_STEP = tccw_pkg::TAB_STEP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        text_attribute,
  input  logic              q_valid,
  input  tccw_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              init_active,
  output logic              result_valid,
  input  logic              result_stall,
  output tccw_pkg::result_t result
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = CELLS - COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int TAB_W      = $clog2(COLUMNS + TAB_STEP);
  localparam int CW         = tccw_pkg::CELL_W;

  tccw_pkg::back_state_t state;
  tccw_pkg::back_state_t state_next;

  tccw_pkg::cmd_t    cmd;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [CW-1:0]     res_data;
  logic              res_scrolled;
  logic [ADDR_W-1:0] fidx;
  logic [CW-1:0]     fill_word;
  logic              report;
  logic [ADDR_W-1:0] sidx;
  logic              copy_pend;
  logic [ADDR_W-1:0] copy_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CW-1:0]     ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CW-1:0]     ram_rdata;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] pos_addr;
  logic [COL_W:0]    col_inc;
  logic [TAB_W-1:0]  tab_sum;
  logic              new_line;
  logic [COL_W-1:0]  step_col;
  logic [ROW_W-1:0]  step_row;
  logic              need_scroll;
  logic              fill_last;
  logic              out_free;

  assign cur_addr  = ADDR_W'(32'(cur_row) * COLUMNS) + ADDR_W'(cur_col);
  assign pos_addr  = ADDR_W'(32'(cmd.cell_row) * COLUMNS) + ADDR_W'(cmd.cell_column);
  assign col_inc   = (COL_W + 1)'(cur_col) + 1'b1;
  assign tab_sum   = TAB_W'(cur_col) + TAB_W'(TAB_STEP);
  assign fill_last = (fidx == ADDR_W'(CELLS - 1));
  assign out_free  = !result_valid || !result_stall;
  assign init_active = (state == tccw_pkg::ST_FILL) && !report;

  // cursor movement for the command in flight
  always_comb begin
    new_line = 1'b0;
    step_col = cur_col;
    case (cmd.kind)
      tccw_pkg::KIND_PUT: begin
        if (32'(col_inc) >= COLUMNS) new_line = 1'b1;
        else                          step_col = COL_W'(col_inc);
      end
      tccw_pkg::KIND_CR:  step_col = '0;
      tccw_pkg::KIND_LF:  new_line = 1'b1;
      tccw_pkg::KIND_TAB: begin
        if (32'(tab_sum) >= COLUMNS) new_line = 1'b1;
        else                          step_col = COL_W'(tab_sum);
      end
      default: step_col = cur_col;
    endcase
    step_row    = cur_row;
    need_scroll = 1'b0;
    if (new_line) begin
      step_col = '0;
      if (cur_row == ROW_W'(ROWS - 1)) need_scroll = 1'b1;
      else                             step_row = cur_row + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tccw_pkg::ST_IDLE: begin
        if (q_valid) state_next = tccw_pkg::ST_EXEC;
      end
      tccw_pkg::ST_EXEC: begin
        if (cmd.kind == tccw_pkg::KIND_CLEAR) begin
          state_next = tccw_pkg::ST_FILL;
        end else if (cmd.kind == tccw_pkg::KIND_READ && cmd.in_range) begin
          state_next = tccw_pkg::ST_READ_WAIT;
        end else if (need_scroll) begin
          state_next = tccw_pkg::ST_SCROLL;
        end else begin
          state_next = tccw_pkg::ST_RESULT;
        end
      end
      tccw_pkg::ST_READ_WAIT: state_next = tccw_pkg::ST_RESULT;
      tccw_pkg::ST_SCROLL: begin
        if (sidx == ADDR_W'(COPY_CELLS)) state_next = tccw_pkg::ST_FILL;
      end
      tccw_pkg::ST_FILL: begin
        if (fill_last) state_next = report ? tccw_pkg::ST_RESULT : tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_RESULT: begin
        if (out_free) state_next = tccw_pkg::ST_IDLE;
      end
      default: state_next = tccw_pkg::ST_IDLE;
    endcase
  end

  // store port and queue controls
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {text_attribute, cmd.char_code};
    ram_raddr = pos_addr;
    unique case (state)
      tccw_pkg::ST_IDLE: q_pop = q_valid;
      tccw_pkg::ST_EXEC: begin
        if (cmd.kind == tccw_pkg::KIND_PUT) begin
          ram_we = 1'b1;
        end else if (cmd.kind == tccw_pkg::KIND_WRITE_AT) begin
          ram_we    = cmd.in_range;
          ram_waddr = pos_addr;
          ram_wdata = {cmd.cell_attribute, cmd.char_code};
        end
      end
      tccw_pkg::ST_SCROLL: begin
        ram_raddr = sidx + ADDR_W'(COLUMNS);
        ram_we    = copy_pend;
        ram_waddr = copy_addr;
        ram_wdata = ram_rdata;
      end
      tccw_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fidx;
        ram_wdata = fill_word;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tccw_pkg::ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // result register valid: loads in ST_RESULT, drops once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == tccw_pkg::ST_RESULT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col      <= '0;
      cur_row      <= '0;
      fidx         <= '0;
      fill_word    <= tccw_pkg::RESET_CELL;
      report       <= 1'b0;
      sidx         <= '0;
      copy_pend    <= 1'b0;
    end else begin
      unique case (state)
        tccw_pkg::ST_IDLE: begin
          if (q_valid) cmd <= q_head;
        end
        tccw_pkg::ST_EXEC: begin
          cur_col      <= step_col;
          cur_row      <= step_row;
          res_scrolled <= need_scroll;
          sidx         <= '0;
          copy_pend    <= 1'b0;
          report       <= 1'b1;
          case (cmd.kind)
            tccw_pkg::KIND_PUT:      res_data <= {text_attribute, cmd.char_code};
            tccw_pkg::KIND_WRITE_AT: res_data <= {cmd.cell_attribute, cmd.char_code};
            tccw_pkg::KIND_CLEAR:    res_data <= {text_attribute, tccw_pkg::CH_SPACE};
            default:                 res_data <= '0;
          endcase
          if (cmd.kind == tccw_pkg::KIND_CLEAR) begin
            fidx      <= '0;
            fill_word <= {text_attribute, tccw_pkg::CH_SPACE};
          end else begin
            // blank bottom row after a scroll copy
            fidx      <= ADDR_W'(COPY_CELLS);
            fill_word <= {text_attribute, tccw_pkg::CH_SPACE};
          end
        end
        tccw_pkg::ST_READ_WAIT: res_data <= ram_rdata;
        tccw_pkg::ST_SCROLL: begin
          copy_pend <= (sidx != ADDR_W'(COPY_CELLS));
          copy_addr <= sidx;
          if (sidx != ADDR_W'(COPY_CELLS)) sidx <= sidx + 1'b1;
        end
        tccw_pkg::ST_FILL: begin
          if (!fill_last) fidx <= fidx + 1'b1;
        end
        tccw_pkg::ST_RESULT: begin
          if (out_free) begin
            result.cell_data     <= res_data;
            result.cursor_column <= 7'(cur_col);
            result.cursor_row    <= 5'(cur_row);
            result.cursor_offset <= 11'(32'(cur_row) * COLUMNS + 32'(cur_col));
            result.scrolled      <= res_scrolled;
          end
        end
        default: report <= report;
      endcase
    end
  end

  tccw_ram #(
    .WIDTH (CW),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### sv/text_console_cell_writer_core.sv
// Text console cell writer: COLUMNS x ROWS cell store with cursor, scroll and clear.
// Path from input transfer to result for put, CR, LF, tab and write-at: front
// register, queue, command fetch, execute, result; an in-range read adds a read wait.
// The back sequencer fetches a new item only once the last result is loaded;
// a stalled result holds it, a scroll adds a copy then blank walk, a clear a fill.
// Reset: synchronous; all COLUMNS*ROWS cells (2000 by default) are filled with
// 0x0720, item_stall held high meanwhile; text_attribute resets to 7.
module text_console_cell_writer_core #(
  parameter int COLUMNS     = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS        = tccw_pkg::ROWS_DEF,
  parameter int TAB_STEP    = tccw_pkg::TAB_STEP_DEF,
  parameter int QUEUE_DEPTH = tccw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           item_valid,
  output logic                           item_stall,
  input  tccw_pkg::item_t                item,
  // results
  output logic                           result_valid,
  input  logic                           result_stall,
  output tccw_pkg::result_t              result,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tccw_pkg::PADDR_W-1:0]   paddr,
  input  logic [tccw_pkg::PDATA_W-1:0]   pwdata,
  output logic [tccw_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  // text_attribute register: write on the access phase of an APB transfer.
  // Register index is paddr[2]; only index 0 exists.
  logic [7:0] text_attribute;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == tccw_pkg::REG_TEXT_ATTR) ?
                     tccw_pkg::PDATA_W'(text_attribute) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tccw_pkg::ATTR_RESET;
    end else if (cfg_write && paddr[2] == tccw_pkg::REG_TEXT_ATTR) begin
      text_attribute <= pwdata[7:0];
    end
  end

  // front: input register and decode into command kinds
  tccw_pkg::cmd_t       front_cmd;
  tccw_pkg::queue_ctl_t qctl;
  logic                 queue_full;
  logic                 init_active;

  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .init_active (init_active),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .qctl_out    (qctl),
    .queue_full  (queue_full),
    .cmd         (front_cmd)
  );

  // queue decouples decode from the long-running back end (scroll, clear)
  logic           q_valid;
  logic           q_pop;
  tccw_pkg::cmd_t q_head;

  tccw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (qctl.push),
    .push_cmd   (front_cmd),
    .full       (queue_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back: cursor, cell store walks and the result register
  tccw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .text_attribute (text_attribute),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .init_active    (init_active),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result)
  );

endmodule

### tb/sv/tb_text_console_cell_writer_core.sv
`timescale 1ns / 1ps
// tb_text_console_cell_writer_core: self-checking testbench for the text console cell writer.
// Depends on tccw_pkg and text_console_cell_writer_core under sv/.
module tb_text_console_cell_writer_core;
  import tccw_pkg::*;

  localparam int COLS           = COLUMNS_DEF;
  localparam int LINES          = ROWS_DEF;
  localparam int TAB_COLS       = TAB_STEP_DEF;
  localparam int CELL_COUNT     = COLS * LINES;
  // no transfer for this long means the block is hung; a scroll or a clear
  // walks about 2000 cells and the reset clearing pass as long again
  localparam int WATCHDOG_LIMIT = 30000;
  // quiet cycles after the last result before a register write or the end
  localparam int SETTLE_CYCLES  = 12;
  localparam int ITEMS_PER_PHASE = 440;

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    psel = 1'b0;
  logic    penable = 1'b0;
  logic    pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic    pready;

  // shadow copy of the console: cell store, cursor and text attribute
  logic [15:0] shadow_screen [0:CELL_COUNT-1];
  int          shadow_col;
  int          shadow_row;
  logic [7:0]  shadow_attr;

  result_t awaited_results [$];
  result_t want_result;
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;

  text_console_cell_writer_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Console predictor
  // ---------------------------------------------------------------------

  // Cursor to column 0 of the next row; past the last row the screen moves
  // up one row and the bottom row is blanked in the current attribute.
  function automatic bit advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row < LINES) return 1'b0;
    for (int i = 0; i < CELL_COUNT; i++)
      shadow_screen[i] = (i + COLS < CELL_COUNT) ? shadow_screen[i + COLS]
                                                 : {shadow_attr, CH_SPACE};
    shadow_row = LINES - 1;
    return 1'b1;
  endfunction

  function automatic result_t predict_console_result(item_t it);
    result_t    res;
    logic [15:0] word;
    bit         scrolled;
    bit         in_range;
    word     = '0;
    scrolled = 1'b0;
    in_range = (it.cell_column < COLS) && (it.cell_row < LINES);
    case (it.action)
      ACT_PUT: begin
        if (it.char_code == CH_CR) begin
          shadow_col = 0;
        end else if (it.char_code == CH_LF) begin
          scrolled = advance_line();
        end else if (it.char_code == CH_TAB) begin
          shadow_col += TAB_COLS;
          // a tab past the last column wraps like a plain character
          if (shadow_col >= COLS) scrolled = advance_line();
        end else begin
          word = {shadow_attr, it.char_code};
          shadow_screen[shadow_row * COLS + shadow_col] = word;
          shadow_col++;
          if (shadow_col >= COLS) scrolled = advance_line();
        end
      end
      ACT_WRITE_AT: begin
        // out-of-range position still reports the word, writes nothing
        word = {it.cell_attribute, it.char_code};
        if (in_range) shadow_screen[it.cell_row * COLS + it.cell_column] = word;
      end
      ACT_READ: begin
        if (in_range) word = shadow_screen[it.cell_row * COLS + it.cell_column];
      end
      default: begin
        word = {shadow_attr, CH_SPACE};
        for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = word;
      end
    endcase
    res.cell_data     = word;
    res.cursor_column = 7'(shadow_col);
    res.cursor_row    = 5'(shadow_row);
    res.cursor_offset = 11'(shadow_row * COLS + shadow_col);
    res.scrolled      = scrolled;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Monitors: every input transfer is predicted, every result transfer checked
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      awaited_results.push_back(predict_console_result(item));
  end

  task automatic note_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0h, got %0h (t=%0t)", what, want, got, $time);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("result with nothing awaited", 0, result);
      end else begin
        want_result = awaited_results.pop_front();
        if (result.cell_data !== want_result.cell_data)
          note_mismatch("cell_data", want_result.cell_data, result.cell_data);
        if (result.cursor_column !== want_result.cursor_column)
          note_mismatch("cursor_column", want_result.cursor_column, result.cursor_column);
        if (result.cursor_row !== want_result.cursor_row)
          note_mismatch("cursor_row", want_result.cursor_row, result.cursor_row);
        if (result.cursor_offset !== want_result.cursor_offset)
          note_mismatch("cursor_offset", want_result.cursor_offset, result.cursor_offset);
        if (result.scrolled !== want_result.scrolled)
          note_mismatch("scrolled", want_result.scrolled, result.scrolled);
      end
    end
  end

  // receiver back-pressure, re-drawn every cycle
  always @(posedge clk)
    result_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);

  // watchdog: any transfer on either channel or the register port resets it
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_text_console_cell_writer_core NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic item_t make_item(action_t act, logic [7:0] ch, logic [7:0] attr,
                                      logic [6:0] col, logic [4:0] row);
    item_t it;
    it.action         = act;
    it.char_code      = ch;
    it.cell_attribute = attr;
    it.cell_column    = col;
    it.cell_row       = row;
    return it;
  endfunction

  // One input transfer. Valid may drop for a random gap first; the payload
  // holds until the transfer edge, where the task returns.
  task automatic send_item(item_t it);
    if ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write with the block idle: setup cycle, then access cycle.
  task automatic write_text_attribute(logic [7:0] value);
    item_valid <= 1'b0;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(REG_TEXT_ATTR));
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_attr = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly text lines (printables with some CR, LF and tab), plus cell
  // writes and reads, a few off-screen positions and rare clears.
  function automatic item_t random_console_item();
    item_t      it;
    int         pick;
    int         kind;
    logic [6:0] col;
    logic [4:0] row;
    it   = item_t'({$urandom, $urandom});
    pick = $urandom_range(999);
    if ($urandom_range(99) < 15) begin
      col = 7'($urandom_range(127));
      row = 5'($urandom_range(31));
    end else begin
      col = 7'($urandom_range(COLS - 1));
      // cell positions lean toward the cursor row, where the text lands
      row = ($urandom_range(1) == 0) ? 5'(shadow_row) : 5'($urandom_range(LINES - 1));
    end
    it.cell_column = col;
    it.cell_row    = row;
    if (pick < 6) begin
      it.action = ACT_CLEAR;
    end else if (pick < 200) begin
      it.action = ACT_WRITE_AT;
    end else if (pick < 400) begin
      it.action = ACT_READ;
    end else begin
      it.action = ACT_PUT;
      kind = $urandom_range(99);
      if (kind < 12)      it.char_code = CH_LF;
      else if (kind < 16) it.char_code = CH_CR;
      else if (kind < 24) it.char_code = CH_TAB;
      else if (kind < 70) it.char_code = 8'($urandom_range(8'h20, 8'h7E));
      else                it.char_code = 8'($urandom_range(255));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Character bytes at the extremes and the control characters, with the
  // attribute still at its reset value.
  task automatic test_put_characters();
    send_item(make_item(ACT_PUT, 8'h41, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_PUT, 8'h00, 8'hFF, 7'd127, 5'd31));
    send_item(make_item(ACT_PUT, 8'hFF, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_PUT, 8'h0F, 8'h5A, 7'd3, 5'd3));
    send_item(make_item(ACT_PUT, 8'h0E, 8'hA5, 7'd4, 5'd4));
    send_item(make_item(ACT_PUT, CH_CR, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_PUT, CH_TAB, 8'h00, 7'd0, 5'd0));
    send_item(make_item(ACT_PUT, CH_LF, 8'h00, 7'd0, 5'd0));
  endtask

  // Write and read at both screen corners and off the screen; the cursor stays.
  task automatic test_cell_access();
    send_item(make_item(ACT_WRITE_AT, 8'h00, 8'hFF, 7'd0, 5'd0));
    send_item(make_item(ACT_WRITE_AT, 8'hFF, 8'h00, 7'(COLS - 1), 5'(LINES - 1)));
    send_item(make_item(ACT_WRITE_AT, 8'h55, 8'hAA, 7'd127, 5'd31));
    send_item(make_item(ACT_WRITE_AT, 8'hAA, 8'h55, 7'(COLS), 5'd5));
    send_item(make_item(ACT_READ, 8'hFF, 8'hFF, 7'd0, 5'd0));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'(COLS - 1), 5'(LINES - 1)));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd127, 5'd31));
  endtask

  // Tabs from column 0 until one overshoots the last column and wraps.
  task automatic test_tab_overshoot();
    for (int i = 0; i < COLS / TAB_COLS; i++)
      send_item(make_item(ACT_PUT, CH_TAB, 8'h00, 7'd0, 5'd0));
  endtask

  // Clear fills with the text attribute; read one cell back.
  task automatic test_clear();
    send_item(make_item(ACT_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31));
    send_item(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
  endtask

  task automatic test_console_traffic(int count, int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_item(random_console_item());
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = RESET_CELL;
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_attr = ATTR_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_put_characters();
    test_cell_access();
    test_tab_overshoot();
    test_clear();

    // free flow, brightest attribute
    write_text_attribute(8'hFF);
    test_console_traffic(ITEMS_PER_PHASE, 0, 0);
    // sender mostly idle, all-zero attribute
    write_text_attribute(8'h00);
    test_console_traffic(ITEMS_PER_PHASE, 69, 0);
    // receiver mostly stalling
    write_text_attribute(8'($urandom_range(255)));
    test_console_traffic(ITEMS_PER_PHASE, 0, 69);
    // light idling on both sides
    write_text_attribute(8'h1E);
    test_console_traffic(ITEMS_PER_PHASE, 16, 16);

    item_valid <= 1'b0;
    wait_drained();
    mismatch_count += awaited_results.size();
    if (mismatch_count == 0)
      $display("tb_text_console_cell_writer_core OK");
    else
      $display("tb_text_console_cell_writer_core NOT OK");
    $finish;
  end

endmodule
